/* hdl/wcsg_pkg.sv */
// ----------------------------------------------------------------------------
// wcsg_pkg
// Shared types and codes for the wave channel sample generator.
// ----------------------------------------------------------------------------
`default_nettype none

package wcsg_pkg;

    // Item kinds carried on the input tuser
    localparam logic [1:0] MODE_REG_WR = 2'd0;
    localparam logic [1:0] MODE_REG_RD = 2'd1;
    localparam logic [1:0] MODE_RAM_WR = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    // Control register byte offsets
    localparam logic [2:0] REG_CTRL    = 3'd0;
    localparam logic [2:0] REG_LENGTH  = 3'd2;
    localparam logic [2:0] REG_VOLUME  = 3'd3;
    localparam logic [2:0] REG_FREQ_LO = 3'd4;
    localparam logic [2:0] REG_FREQ_HI = 3'd5;

    // Volume codes
    localparam logic [1:0] VOL_MUTE    = 2'd0;
    localparam logic [1:0] VOL_FULL    = 2'd1;
    localparam logic [1:0] VOL_HALF    = 2'd2;
    localparam logic [1:0] VOL_QUARTER = 2'd3;

    localparam int RAM_DEPTH = 32;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    typedef struct packed {
        logic [3:0] ram_index;
        logic       ram_bank;
        logic [7:0] data_byte;
        logic [2:0] reg_offset;
        logic [1:0] mode;
    } item_t;

    typedef struct packed {
        logic              active;
        logic [10:0]       period_code;
        logic signed [7:0] sample_out;
        logic [7:0]        read_data;
    } result_t;

endpackage

`default_nettype wire

/* hdl/wcsg_in_stage.sv */
// ----------------------------------------------------------------------------
// wcsg_in_stage
// Input register: captures one word from the slave side per cycle while it is empty or its held word moves on.
// ----------------------------------------------------------------------------
`default_nettype none

module wcsg_in_stage
    import wcsg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       item_valid,
    output item_t      item,
    input  wire logic  advance
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Take a new word when empty or whenever the held one moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* hdl/wcsg_core.sv */
// ----------------------------------------------------------------------------
// wcsg_core
// Channel state, wave memory and the per-item update and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module wcsg_core
    import wcsg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    output result_t    result
);

    logic [4:0]        phase_reg,   phase_next;
    logic signed [7:0] sample_reg,  sample_next;
    logic              play_reg,    play_next;
    logic              trig_reg,    trig_next;
    logic              force34_reg, force34_next;
    logic [1:0]        vol_reg,     vol_next;
    logic [10:0]       freq_reg,    freq_next;
    logic              two_bank_reg, two_bank_next;
    logic              bank_reg,    bank_next;
    logic              len_en_reg,  len_en_next;
    logic [7:0]        wave_mem_reg [RAM_DEPTH];

    logic [7:0]        rd_data;
    logic [7:0]        cur_byte;
    logic [3:0]        nib;
    logic signed [7:0] centered;
    logic signed [7:0] scaled;
    logic              mem_we;
    logic [RAM_AW-1:0] mem_addr;

    // Wave byte for the current phase and its nibble, centered around zero
    assign cur_byte = wave_mem_reg[{bank_reg, phase_reg[4:1]}];
    assign nib      = phase_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
    assign centered = {{4{~nib[3]}}, ~nib[3], nib[2:0]};

    // Volume scaling, including the forced three-quarter level
    always_comb
    begin
        if (force34_reg)
        begin
            scaled = (centered <<< 3) + (centered <<< 2);
        end
        else
        begin
            unique case (vol_reg)
                VOL_MUTE:    scaled = '0;
                VOL_FULL:    scaled = centered <<< 4;
                VOL_HALF:    scaled = centered <<< 3;
                VOL_QUARTER: scaled = centered <<< 2;
                default:     scaled = '0;
            endcase
        end
    end

    // Next state per item kind
    always_comb
    begin
        phase_next    = phase_reg;
        sample_next   = sample_reg;
        play_next     = play_reg;
        trig_next     = trig_reg;
        force34_next  = force34_reg;
        vol_next      = vol_reg;
        freq_next     = freq_reg;
        two_bank_next = two_bank_reg;
        bank_next     = bank_reg;
        len_en_next   = len_en_reg;
        rd_data       = '0;
        mem_we        = 1'b0;
        mem_addr      = {item.ram_bank, item.ram_index};

        unique case (item.mode)
            MODE_REG_WR:
            begin
                unique case (item.reg_offset)
                    REG_CTRL:
                    begin
                        two_bank_next = item.data_byte[5];
                        bank_next     = item.data_byte[6];
                        play_next     = item.data_byte[7];
                    end
                    REG_VOLUME:
                    begin
                        vol_next     = item.data_byte[6:5];
                        force34_next = item.data_byte[7];
                    end
                    REG_FREQ_LO:
                    begin
                        freq_next[7:0] = item.data_byte;
                    end
                    REG_FREQ_HI:
                    begin
                        freq_next[10:8] = item.data_byte[2:0];
                        len_en_next     = item.data_byte[6];
                        // trigger: restart playback from step zero
                        if (play_reg && item.data_byte[7])
                        begin
                            phase_next = '0;
                            trig_next  = 1'b1;
                            if (two_bank_reg)
                            begin
                                bank_next = 1'b0;
                            end
                        end
                    end
                    default: ;  // length and unused offsets
                endcase
            end
            MODE_REG_RD:
            begin
                unique case (item.reg_offset)
                    REG_CTRL:    rd_data = {play_reg, bank_reg, two_bank_reg, 5'b0};
                    REG_VOLUME:  rd_data = {force34_reg, vol_reg, 5'b0};
                    REG_FREQ_HI: rd_data = {1'b0, len_en_reg, 6'b0};
                    default:     rd_data = '0;
                endcase
            end
            MODE_RAM_WR:
            begin
                mem_we = 1'b1;
            end
            MODE_TICK:
            begin
                if (play_reg && trig_reg)
                begin
                    sample_next = scaled;
                    phase_next  = phase_reg + 5'd1;
                    if (&phase_reg && two_bank_reg)
                    begin
                        bank_next = ~bank_reg;
                    end
                end
                else
                begin
                    sample_next = '0;
                end
            end
            default: ;
        endcase
    end

    // Result seen after this item's update
    assign result.read_data   = rd_data;
    assign result.sample_out  = sample_next;
    assign result.period_code = freq_next;
    assign result.active      = play_next && trig_next;

    // Channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= '0;
            sample_reg   <= '0;
            play_reg     <= 1'b0;
            trig_reg     <= 1'b0;
            force34_reg  <= 1'b0;
            vol_reg      <= '0;
            freq_reg     <= '0;
            two_bank_reg <= 1'b0;
            bank_reg     <= 1'b0;
            len_en_reg   <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            sample_reg   <= sample_next;
            play_reg     <= play_next;
            trig_reg     <= trig_next;
            force34_reg  <= force34_next;
            vol_reg      <= vol_next;
            freq_reg     <= freq_next;
            two_bank_reg <= two_bank_next;
            bank_reg     <= bank_next;
            len_en_reg   <= len_en_next;
        end
    end

    // Wave memory, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RAM_DEPTH; i++)
            begin
                wave_mem_reg[i] <= '0;
            end
        end
        else if (fire && mem_we)
        begin
            wave_mem_reg[mem_addr] <= item.data_byte;
        end
    end

endmodule

`default_nettype wire

/* hdl/wcsg_out_stage.sv */
// ----------------------------------------------------------------------------
// wcsg_out_stage
// Result register: holds one word for the master side until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wcsg_out_stage
    import wcsg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    res_valid,
    input  wire result_t res,
    output logic         can_load,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    valid_reg;
    result_t res_reg;

    // Free when empty or when the held word leaves this cycle
    assign can_load = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

/* hdl/wave_channel_sample_generator_unit.sv */
// ----------------------------------------------------------------------------
// wave_channel_sample_generator_unit
// Wave sound channel with two 16-byte wave banks and a 32-step phase.
// ----------------------------------------------------------------------------
// Every input word (register write, register read, wave memory write or
// sample tick) yields exactly one output word carrying the read value, the
// current signed sample, the 11-bit period code and the active flag after
// that word's update. The unit takes one word per clock cycle; each word
// passes the input register, then the update logic into the result
// register, and throughput drops only while the master side holds tready
// low. The wave memory is cleared by reset, so it is usable at once.
`default_nettype none

module wave_channel_sample_generator_unit
    import wcsg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // reg_offset[2:0], data_byte[10:3],
                                        // ram_bank[11], ram_index[15:12]
    input  wire logic [1:0]  s_tuser,   // mode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // read_data[7:0], sample_out[15:8],
                                        // period_code[26:16], active[27]
);

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    can_load;
    result_t core_res;
    result_t out_res;

    // Unpack the input word
    assign in_item.mode       = s_tuser;
    assign in_item.reg_offset = s_tdata[2:0];
    assign in_item.data_byte  = s_tdata[10:3];
    assign in_item.ram_bank   = s_tdata[11];
    assign in_item.ram_index  = s_tdata[15:12];

    wcsg_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .advance    (can_load)
    );

    wcsg_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (item_valid && can_load),
        .item   (item),
        .result (core_res)
    );

    wcsg_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (item_valid),
        .res       (core_res),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    // Pack the output word
    assign m_tdata = {4'b0, out_res.active, out_res.period_code,
                      out_res.sample_out, out_res.read_data};

    // An empty output side never blocks the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result register");

    // Read values only use bits 7:5
    a_read_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:0] == 5'd0))
        else $error("read data low bits set");

    // Samples are multiples of four and never above +112
    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[9:8] == 2'd0) &&
                      !((m_tdata[15] == 1'b0) && (m_tdata[14:8] > 7'd112))))
        else $error("sample out of range");

endmodule

`default_nettype wire

/* verif/wave_channel_sample_checker.sv */
// ----------------------------------------------------------------------------
// wave_channel_sample_checker
// Scoreboard for the wave channel sample generator.
// ----------------------------------------------------------------------------
// Watches both stream channels. Every word accepted on the slave side runs
// through a local model of the channel (registers, wave memory, phase, bank)
// and its predicted output word is queued. Every word accepted on the master
// side is compared field by field against the oldest queued prediction.
// ----------------------------------------------------------------------------

module wave_channel_sample_checker
    import wcsg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // reg_offset, data_byte, ram_bank, ram_index
    input  logic [1:0]  s_tuser,    // mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,    // read_data, sample_out, period_code, active
    output int          words_in,
    output int          words_out,
    output int          mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    // Model state of the channel
    logic [4:0]  phase;
    logic [7:0]  sample;
    logic        play_en;
    logic        trig;
    logic        three_q;
    logic [1:0]  vol;
    logic [10:0] freq;
    logic        dual_bank;
    logic        bank;
    logic        len_en;
    logic [7:0]  wave_mem [RAM_DEPTH];

    result_t     expected_words [$];
    result_t     want;
    result_t     got;

    // Apply one input word to the model, return the output word it yields
    function automatic result_t advance_channel(item_t w);
        result_t    r;
        logic [7:0] wbyte;
        logic [3:0] nib;
        int         factor;
        int         level;
        r = '0;
        case (w.mode)
            MODE_REG_WR:
            begin
                case (w.reg_offset)
                    REG_CTRL:
                    begin
                        dual_bank = w.data_byte[5];
                        bank      = w.data_byte[6];
                        play_en   = w.data_byte[7];
                    end
                    REG_VOLUME:
                    begin
                        vol     = w.data_byte[6:5];
                        three_q = w.data_byte[7];
                    end
                    REG_FREQ_LO:
                        freq[7:0] = w.data_byte;
                    REG_FREQ_HI:
                    begin
                        freq[10:8] = w.data_byte[2:0];
                        len_en     = w.data_byte[6];
                        // trigger: restart phase, and bank in two-bank mode
                        if (play_en && w.data_byte[7])
                        begin
                            phase = '0;
                            if (dual_bank)
                                bank = 1'b0;
                            trig = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            MODE_REG_RD:
            begin
                case (w.reg_offset)
                    REG_CTRL:    r.read_data = {play_en, bank, dual_bank, 5'b0};
                    REG_VOLUME:  r.read_data = {three_q, vol, 5'b0};
                    REG_FREQ_HI: r.read_data = {1'b0, len_en, 6'b0};
                    default:     r.read_data = '0;
                endcase
            end
            MODE_RAM_WR:
                wave_mem[{w.ram_bank, w.ram_index}] = w.data_byte;
            default:
            begin
                // sample tick
                if (!(play_en && trig))
                    sample = '0;
                else
                begin
                    wbyte = wave_mem[{bank, phase[4:1]}];
                    nib   = phase[0] ? wbyte[3:0] : wbyte[7:4];
                    if (three_q)
                        factor = 3;
                    else if (vol == VOL_FULL)
                        factor = 4;
                    else if (vol == VOL_HALF)
                        factor = 2;
                    else if (vol == VOL_QUARTER)
                        factor = 1;
                    else
                        factor = 0;
                    level  = (int'(nib) - 8) * 4 * factor;
                    sample = level[7:0];
                    phase  = phase + 5'd1;
                    if (phase == 5'd0 && dual_bank)
                        bank = ~bank;
                end
            end
        endcase
        r.sample_out  = sample;
        r.period_code = freq;
        r.active      = play_en && trig;
        return r;
    endfunction

    // Predict on input handshakes, compare on output handshakes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase     = '0;
            sample    = '0;
            play_en   = 1'b0;
            trig      = 1'b0;
            three_q   = 1'b0;
            vol       = VOL_MUTE;
            freq      = '0;
            dual_bank = 1'b0;
            bank      = 1'b0;
            len_en    = 1'b0;
            for (int i = 0; i < RAM_DEPTH; i++)
                wave_mem[i] = '0;
            expected_words.delete();
            words_in   <= 0;
            words_out  <= 0;
            mismatches <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_words.push_back(advance_channel(item_t'({s_tdata, s_tuser})));
                words_in <= words_in + 1;
            end
            if (m_tvalid && m_tready)
            begin
                words_out <= words_out + 1;
                got = result_t'(m_tdata[27:0]);
                if (expected_words.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: output word %08h with nothing expected", $realtime,
                                 m_tdata);
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want || m_tdata[31:28] !== 4'b0)
                    begin
                        if (mismatches < 10)
                            $display({"%0t: mismatch expected rd=%02h smp=%0d per=%03h ",
                                      "act=%0b, got rd=%02h smp=%0d per=%03h act=%0b pad=%h"},
                                     $realtime, want.read_data, want.sample_out,
                                     want.period_code, want.active, got.read_data,
                                     got.sample_out, got.period_code, got.active,
                                     m_tdata[31:28]);
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

/* verif/wave_channel_sample_generator_unit_tb.sv */
// ----------------------------------------------------------------------------
// wave_channel_sample_generator_unit_tb
// Stimulus and verdict for the wave channel sample generator.
// ----------------------------------------------------------------------------
// Drives a directed sequence (sample extremes, volume scaling, trigger and
// bank handling, unused offsets, register reads) and then random words
// weighted toward playing the channel, with random gaps on the slave side
// and random stalls on the master side. The checker scores the output.
// ----------------------------------------------------------------------------

module wave_channel_sample_generator_unit_tb
    import wcsg_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Offsets that decode to nothing
    localparam logic [2:0] REG_NONE_1 = 3'd1;
    localparam logic [2:0] REG_NONE_6 = 3'd6;
    localparam logic [2:0] REG_NONE_7 = 3'd7;

    localparam int RANDOM_WORDS = 400;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // reg_offset, data_byte, ram_bank, ram_index
    logic [1:0]  s_tuser;   // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // read_data, sample_out, period_code, active

    int          words_in;
    int          words_out;
    int          mismatches;
    bit          steady;

    wave_channel_sample_generator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wave_channel_sample_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .words_in   (words_in),
        .words_out  (words_out),
        .mismatches (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Present one word and hold it until accepted
    task automatic send_word(input logic [1:0] mode, input logic [2:0] off,
                             input logic [7:0] data, input logic rbank,
                             input logic [3:0] idx);
        int gap;
        s_tuser  <= mode;
        s_tdata  <= {idx, rbank, data, off};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        gap = steady ? 0 : idle_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random word, weighted toward ticks and live register writes
    task automatic send_random();
        int         r;
        logic [7:0] data;
        logic [2:0] off;
        logic       rbank;
        logic [3:0] idx;
        r     = $urandom_range(0, 99);
        data  = 8'($urandom_range(0, 255));
        off   = 3'($urandom_range(0, 7));
        rbank = 1'($urandom_range(0, 1));
        idx   = 4'($urandom_range(0, 15));
        if (r < 45)
            send_word(MODE_TICK, off, data, rbank, idx);
        else if (r < 70)
            send_word(MODE_RAM_WR, off, data, rbank, idx);
        else if (r < 90)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    off     = REG_CTRL;
                    data[7] = ($urandom_range(0, 4) != 0);   // keep it playing mostly
                end
                2, 3:    off = REG_VOLUME;
                4, 5:    off = REG_FREQ_HI;
                6:       off = REG_FREQ_LO;
                default: ;
            endcase
            send_word(MODE_REG_WR, off, data, rbank, idx);
        end
        else
            send_word(MODE_REG_RD, off, data, rbank, idx);
    endtask

    // Master side: ready runs broken by random stalls
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(50, 120)) @(posedge clk);
            else
                repeat ($urandom_range(0, 24)) @(posedge clk);
            stall = idle_len();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = MODE_TICK;
        steady   = 1'b0;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick while off gives zero
        send_word(MODE_TICK, REG_CTRL, 8'hFF, 1'b1, 4'hF);
        // nibble extremes in both banks
        send_word(MODE_RAM_WR, REG_CTRL, 8'h0F, 1'b0, 4'h0);
        send_word(MODE_RAM_WR, REG_CTRL, 8'hF0, 1'b1, 4'hF);
        // play single bank, full volume, max period, trigger
        send_word(MODE_REG_WR, REG_CTRL, 8'h80, 1'b0, 4'h0);
        send_word(MODE_REG_WR, REG_VOLUME, 8'h20, 1'b0, 4'h0);
        send_word(MODE_REG_WR, REG_FREQ_LO, 8'hFF, 1'b0, 4'h0);
        send_word(MODE_REG_WR, REG_FREQ_HI, 8'h87, 1'b0, 4'h0);
        send_word(MODE_TICK, REG_CTRL, 8'h00, 1'b0, 4'h0);
        send_word(MODE_TICK, REG_CTRL, 8'h00, 1'b0, 4'h0);
        // forced three-quarter overrides the volume code
        send_word(MODE_REG_WR, REG_VOLUME, 8'hE0, 1'b0, 4'h0);
        send_word(MODE_TICK, REG_CTRL, 8'h00, 1'b0, 4'h0);
        // length and unused offsets have no effect
        send_word(MODE_REG_WR, REG_LENGTH, 8'hFF, 1'b0, 4'h0);
        send_word(MODE_REG_WR, REG_NONE_1, 8'hFF, 1'b0, 4'h0);
        send_word(MODE_REG_WR, REG_NONE_6, 8'hFF, 1'b0, 4'h0);
        send_word(MODE_REG_WR, REG_NONE_7, 8'hFF, 1'b0, 4'h0);
        for (int o = 0; o < 8; o++)
            send_word(MODE_REG_RD, 3'(o), 8'h00, 1'b0, 4'h0);
        // stop play: inactive, but trigger persists when play returns
        send_word(MODE_REG_WR, REG_CTRL, 8'h00, 1'b0, 4'h0);
        send_word(MODE_TICK, REG_CTRL, 8'h00, 1'b0, 4'h0);
        send_word(MODE_REG_WR, REG_CTRL, 8'hE0, 1'b0, 4'h0);
        send_word(MODE_TICK, REG_CTRL, 8'h00, 1'b0, 4'h0);
        // trigger in two-bank mode resets the bank; no trigger while off
        send_word(MODE_REG_WR, REG_FREQ_HI, 8'hC0, 1'b0, 4'h0);
        send_word(MODE_REG_WR, REG_CTRL, 8'h60, 1'b0, 4'h0);
        send_word(MODE_REG_WR, REG_FREQ_HI, 8'h80, 1'b0, 4'h0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 50 == 0)
                steady = ($urandom_range(0, 3) == 0);
            send_random();
        end
        s_tvalid <= 1'b0;

        // drain outstanding words before giving the verdict
        do
            @(posedge clk);
        while (words_out != words_in);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
